/* src/nfs_pkg.sv */
// Shared types and constants of the flow-shop scheduler.
package nfs_pkg;

   localparam int MAX_JOBS     = 32;
   localparam int MAX_MACHINES = 16;
   localparam int TIME_BITS    = 16;
   localparam int JOB_W        = 5;
   localparam int MACH_W       = 4;
   localparam int ADDR_W       = JOB_W + MACH_W;
   localparam int TOTAL_W      = 21;
   localparam int SPAN_W       = 25;
   localparam int JC_W         = 6;
   localparam int MC_W         = 5;
   localparam int CSR_IDX_W    = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_JOB_COUNT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MACHINE_COUNT = 2'd1;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_SCAN,
      OP_PICK,
      OP_TRIAL_INIT,
      OP_READ,
      OP_CALC,
      OP_TRIAL_END,
      OP_INS_END,
      OP_EMIT_INIT,
      OP_EMIT
   } op_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SCAN,
      ST_PICK,
      ST_TRIAL_INIT,
      ST_READ,
      ST_CALC,
      ST_TRIAL_END,
      ST_INS_END,
      ST_EMIT_INIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic last_load;
      logic scan_end;
      logic rank_end;
      logic single;
      logic m_end;
      logic k_end;
      logic pos_end;
      logic i_end;
      logic emit_done;
   } dp_stat_type;

endpackage

/* src/nfs_ctrl.sv */
// Sequencer of load, sort, insertion search and result phases.
module nfs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  nfs_pkg::dp_stat_type stat,
   output nfs_pkg::dp_cmd_type  cmd
);

   nfs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nfs_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = nfs_pkg::OP_NONE;
      req_stall = 1'b1;
      unique case (state_ff)
         nfs_pkg::ST_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op = nfs_pkg::OP_LOAD;
               if (stat.last_load) state_in = nfs_pkg::ST_SCAN;
            end
         end
         nfs_pkg::ST_SCAN: begin
            cmd.op = nfs_pkg::OP_SCAN;
            if (stat.scan_end) state_in = nfs_pkg::ST_PICK;
         end
         nfs_pkg::ST_PICK: begin
            cmd.op = nfs_pkg::OP_PICK;
            if (!stat.rank_end) state_in = nfs_pkg::ST_SCAN;
            else if (stat.single) state_in = nfs_pkg::ST_EMIT_INIT;
            else state_in = nfs_pkg::ST_TRIAL_INIT;
         end
         nfs_pkg::ST_TRIAL_INIT: begin
            cmd.op   = nfs_pkg::OP_TRIAL_INIT;
            state_in = nfs_pkg::ST_READ;
         end
         nfs_pkg::ST_READ: begin
            cmd.op   = nfs_pkg::OP_READ;
            state_in = nfs_pkg::ST_CALC;
         end
         nfs_pkg::ST_CALC: begin
            cmd.op = nfs_pkg::OP_CALC;
            if (stat.m_end && stat.k_end) state_in = nfs_pkg::ST_TRIAL_END;
            else state_in = nfs_pkg::ST_READ;
         end
         nfs_pkg::ST_TRIAL_END: begin
            cmd.op = nfs_pkg::OP_TRIAL_END;
            if (stat.pos_end) state_in = nfs_pkg::ST_INS_END;
            else state_in = nfs_pkg::ST_TRIAL_INIT;
         end
         nfs_pkg::ST_INS_END: begin
            cmd.op = nfs_pkg::OP_INS_END;
            if (stat.i_end) state_in = nfs_pkg::ST_EMIT_INIT;
            else state_in = nfs_pkg::ST_TRIAL_INIT;
         end
         nfs_pkg::ST_EMIT_INIT: begin
            cmd.op   = nfs_pkg::OP_EMIT_INIT;
            state_in = nfs_pkg::ST_EMIT;
         end
         nfs_pkg::ST_EMIT: begin
            cmd.op = nfs_pkg::OP_EMIT;
            if (stat.emit_done) state_in = nfs_pkg::ST_LOAD;
         end
         default: begin
            state_in = nfs_pkg::ST_LOAD;
         end
      endcase
   end

endmodule

/* src/nfs_dpath.sv */
// Time store, job totals, sort, makespan recurrence and result register.
module nfs_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  nfs_pkg::dp_cmd_type                  cmd,
   output nfs_pkg::dp_stat_type                 stat,
   input  logic                                 csr_we,
   input  logic [nfs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [nfs_pkg::JC_W-1:0]             csr_wdata,
   input  logic [nfs_pkg::TIME_BITS-1:0]        req_proc_time,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic [nfs_pkg::JC_W-1:0]             rsp_job_number,
   output logic [nfs_pkg::SPAN_W-1:0]           rsp_makespan,
   output logic                                 rsp_last
);

   localparam int JOB_W  = nfs_pkg::JOB_W;
   localparam int MACH_W = nfs_pkg::MACH_W;
   localparam int SPAN_W = nfs_pkg::SPAN_W;

   logic [nfs_pkg::TIME_BITS-1:0] time_mem [nfs_pkg::MAX_JOBS*nfs_pkg::MAX_MACHINES];
   logic [nfs_pkg::TIME_BITS-1:0] rdata_ff;

   logic [nfs_pkg::JC_W-1:0]    jc_ff;
   logic [nfs_pkg::MC_W-1:0]    mc_ff;
   logic [nfs_pkg::TOTAL_W-1:0] total_ff [nfs_pkg::MAX_JOBS];
   logic [JOB_W-1:0]            load_job_ff;
   logic [MACH_W-1:0]           load_mach_ff;

   logic [nfs_pkg::MAX_JOBS-1:0] picked_ff;
   logic [JOB_W-1:0]             j_ff, r_ff, cand_ff;
   logic [nfs_pkg::TOTAL_W-1:0]  cand_tot_ff;
   logic                         have_ff;
   logic [JOB_W-1:0]             order_ff [nfs_pkg::MAX_JOBS];
   logic [JOB_W-1:0]             best_ff  [nfs_pkg::MAX_JOBS];

   logic [JOB_W-1:0]  i_ff, pos_ff, k_ff, best_pos_ff, e_ff;
   logic [MACH_W-1:0] m_ff;
   logic [SPAN_W-1:0] prev_ff, best_ms_ff;
   logic [SPAN_W-1:0] row_ff [nfs_pkg::MAX_MACHINES];
   logic              rsp_valid_ff, rsp_last_ff;
   logic [nfs_pkg::JC_W-1:0]  rsp_job_ff;
   logic [SPAN_W-1:0]         rsp_ms_ff;

   logic [nfs_pkg::JC_W-1:0] jc_eff;
   logic [nfs_pkg::MC_W-1:0] mc_eff;
   logic [JOB_W-1:0]         jc_m1;
   logic [MACH_W-1:0]        mc_m1;
   logic [JOB_W-1:0]         slot_job;
   logic [SPAN_W-1:0]        start, calc_val;
   logic                     accept_out;
   logic                     csr_hit;

   always_comb begin
      if (jc_ff == '0) jc_eff = nfs_pkg::JC_W'(1);
      else if (jc_ff > nfs_pkg::JC_W'(nfs_pkg::MAX_JOBS))
         jc_eff = nfs_pkg::JC_W'(nfs_pkg::MAX_JOBS);
      else jc_eff = jc_ff;
      if (mc_ff == '0) mc_eff = nfs_pkg::MC_W'(1);
      else if (mc_ff > nfs_pkg::MC_W'(nfs_pkg::MAX_MACHINES))
         mc_eff = nfs_pkg::MC_W'(nfs_pkg::MAX_MACHINES);
      else mc_eff = mc_ff;
      jc_m1 = JOB_W'(jc_eff - nfs_pkg::JC_W'(1));
      mc_m1 = MACH_W'(mc_eff - nfs_pkg::MC_W'(1));
   end

   always_comb begin
      if (k_ff < pos_ff) slot_job = best_ff[k_ff];
      else if (k_ff == pos_ff) slot_job = order_ff[i_ff];
      else slot_job = best_ff[k_ff - JOB_W'(1)];
      start = row_ff[m_ff];
      if (m_ff != '0 && prev_ff > start) start = prev_ff;
      calc_val = start + SPAN_W'(rdata_ff);
   end

   assign accept_out = rsp_valid_ff && !rsp_stall;
   assign csr_hit    = csr_we && (csr_index == nfs_pkg::CSR_JOB_COUNT ||
                                  csr_index == nfs_pkg::CSR_MACHINE_COUNT);

   always_comb begin
      stat.last_load = (load_job_ff == jc_m1) && (load_mach_ff == mc_m1);
      stat.scan_end  = (j_ff == jc_m1);
      stat.rank_end  = (r_ff == jc_m1);
      stat.single    = (jc_m1 == '0);
      stat.m_end     = (m_ff == mc_m1);
      stat.k_end     = (k_ff == i_ff);
      stat.pos_end   = (pos_ff == i_ff);
      stat.i_end     = (i_ff == jc_m1);
      stat.emit_done = accept_out && rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.op == nfs_pkg::OP_LOAD) time_mem[{load_job_ff, load_mach_ff}] <= req_proc_time;
      if (cmd.op == nfs_pkg::OP_READ) rdata_ff <= time_mem[{slot_job, m_ff}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         jc_ff        <= nfs_pkg::JC_W'(1);
         mc_ff        <= nfs_pkg::MC_W'(1);
         load_job_ff  <= '0;
         load_mach_ff <= '0;
         picked_ff    <= '0;
         have_ff      <= 1'b0;
         j_ff         <= '0;
         r_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         for (int n = 0; n < nfs_pkg::MAX_JOBS; n++) total_ff[n] <= '0;
      end else if (csr_hit) begin
         if (csr_index == nfs_pkg::CSR_JOB_COUNT) jc_ff <= csr_wdata;
         else mc_ff <= csr_wdata[nfs_pkg::MC_W-1:0];
         load_job_ff  <= '0;
         load_mach_ff <= '0;
         for (int n = 0; n < nfs_pkg::MAX_JOBS; n++) total_ff[n] <= '0;
      end else begin
         unique case (cmd.op)
            nfs_pkg::OP_LOAD: begin
               total_ff[load_job_ff] <= total_ff[load_job_ff] + nfs_pkg::TOTAL_W'(req_proc_time);
               if (load_mach_ff == mc_m1) begin
                  load_mach_ff <= '0;
                  load_job_ff  <= stat.last_load ? '0 : load_job_ff + JOB_W'(1);
               end else begin
                  load_mach_ff <= load_mach_ff + MACH_W'(1);
               end
            end
            nfs_pkg::OP_SCAN: begin
               if (!picked_ff[j_ff] && (!have_ff || total_ff[j_ff] > cand_tot_ff)) begin
                  have_ff     <= 1'b1;
                  cand_ff     <= j_ff;
                  cand_tot_ff <= total_ff[j_ff];
               end
               j_ff <= j_ff + JOB_W'(1);
            end
            nfs_pkg::OP_PICK: begin
               order_ff[r_ff] <= cand_ff;
               have_ff        <= 1'b0;
               j_ff           <= '0;
               if (r_ff == '0) best_ff[0] <= cand_ff;
               if (stat.rank_end) begin
                  r_ff       <= '0;
                  picked_ff  <= '0;
                  i_ff       <= JOB_W'(1);
                  pos_ff     <= '0;
                  best_ms_ff <= SPAN_W'(cand_tot_ff);
               end else begin
                  r_ff               <= r_ff + JOB_W'(1);
                  picked_ff[cand_ff] <= 1'b1;
               end
            end
            nfs_pkg::OP_TRIAL_INIT: begin
               for (int n = 0; n < nfs_pkg::MAX_MACHINES; n++) row_ff[n] <= '0;
               k_ff <= '0;
               m_ff <= '0;
            end
            nfs_pkg::OP_READ: begin
            end
            nfs_pkg::OP_CALC: begin
               row_ff[m_ff] <= calc_val;
               prev_ff      <= calc_val;
               if (stat.m_end) begin
                  m_ff <= '0;
                  k_ff <= k_ff + JOB_W'(1);
               end else begin
                  m_ff <= m_ff + MACH_W'(1);
               end
            end
            nfs_pkg::OP_TRIAL_END: begin
               if (pos_ff == '0 || prev_ff < best_ms_ff) begin
                  best_ms_ff  <= prev_ff;
                  best_pos_ff <= pos_ff;
               end
               pos_ff <= pos_ff + JOB_W'(1);
            end
            nfs_pkg::OP_INS_END: begin
               for (int n = 0; n < nfs_pkg::MAX_JOBS; n++) begin
                  if (JOB_W'(n) == best_pos_ff) best_ff[n] <= order_ff[i_ff];
                  else if (n > 0 && JOB_W'(n) > best_pos_ff && JOB_W'(n) <= i_ff)
                     best_ff[n] <= best_ff[n-1];
               end
               pos_ff <= '0;
               i_ff   <= i_ff + JOB_W'(1);
            end
            nfs_pkg::OP_EMIT_INIT: begin
               e_ff         <= '0;
               rsp_valid_ff <= 1'b1;
               rsp_job_ff   <= nfs_pkg::JC_W'(best_ff[0]) + nfs_pkg::JC_W'(1);
               rsp_ms_ff    <= best_ms_ff;
               rsp_last_ff  <= stat.single;
            end
            nfs_pkg::OP_EMIT: begin
               if (accept_out) begin
                  if (rsp_last_ff) begin
                     rsp_valid_ff <= 1'b0;
                     for (int n = 0; n < nfs_pkg::MAX_JOBS; n++) total_ff[n] <= '0;
                  end else begin
                     e_ff        <= e_ff + JOB_W'(1);
                     rsp_job_ff  <= nfs_pkg::JC_W'(best_ff[e_ff + JOB_W'(1)]) + nfs_pkg::JC_W'(1);
                     rsp_last_ff <= (e_ff + JOB_W'(1) == jc_m1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_job_number = rsp_job_ff;
   assign rsp_makespan   = rsp_ms_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

/* src/neh_flow_shop_scheduler_unit.sv */
// Top level of the NEH permutation flow-shop scheduler.
// Load job_count x machine_count processing times, one item per cycle, job-major.
// After the last time the input stalls while the block sorts the jobs by
// descending total (one job compared per cycle), then runs the insertion
// search: each trial evaluates the max-plus recurrence with a time store
// read, then an add, for each job and machine. The J results then leave
// one per cycle while not stalled; the next instance may load after the
// last result is taken. Configuration written while idle restarts the load.
module neh_flow_shop_scheduler_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [nfs_pkg::TIME_BITS-1:0]        req_proc_time,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [nfs_pkg::JC_W-1:0]             rsp_job_number,
   output logic [nfs_pkg::SPAN_W-1:0]           rsp_makespan,
   output logic                                 rsp_last,
   input  logic                                 csr_we,
   input  logic [nfs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [nfs_pkg::JC_W-1:0]             csr_wdata
);

   nfs_pkg::dp_cmd_type  cmd;
   nfs_pkg::dp_stat_type stat;

   nfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   nfs_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_proc_time  (req_proc_time),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_job_number (rsp_job_number),
      .rsp_makespan   (rsp_makespan),
      .rsp_last       (rsp_last)
   );

   a_no_load_while_emit: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && !req_stall && rsp_valid))
      else $error("item accepted while results pending");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_last_ends_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last) |=> !rsp_valid)
      else $error("result after final item");

   a_job_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_job_number != '0))
      else $error("zero job number");

endmodule

/* sim/nfs_checker.sv */
// Checker of the flow-shop scheduler: predicts each final sequence and compares the results.
module nfs_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [nfs_pkg::TIME_BITS-1:0]        req_proc_time,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic [nfs_pkg::JC_W-1:0]             rsp_job_number,
   input  logic [nfs_pkg::SPAN_W-1:0]           rsp_makespan,
   input  logic                                 rsp_last,
   input  logic                                 csr_we,
   input  logic [nfs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [nfs_pkg::JC_W-1:0]             csr_wdata,
   output int                                   fail_count,
   output int                                   pending,
   output int                                   result_count
);
   localparam int JC_W         = nfs_pkg::JC_W;
   localparam int MC_W         = nfs_pkg::MC_W;
   localparam int SPAN_W       = nfs_pkg::SPAN_W;
   localparam int TIME_BITS    = nfs_pkg::TIME_BITS;
   localparam int TOTAL_W      = nfs_pkg::TOTAL_W;
   localparam int MAX_JOBS     = nfs_pkg::MAX_JOBS;
   localparam int MAX_MACHINES = nfs_pkg::MAX_MACHINES;

   typedef struct packed {
      logic [JC_W-1:0]   job_number;
      logic [SPAN_W-1:0] makespan;
      logic              last;
   } sched_result_type;

   sched_result_type       sched_expect_q[$];
   logic [TIME_BITS-1:0]   proc_times[MAX_JOBS][MAX_MACHINES];
   logic [TOTAL_W-1:0]     job_sums[MAX_JOBS];
   logic [JC_W-1:0]        jobs_reg;
   logic [MC_W-1:0]        machines_reg;
   int                     loaded;

   function automatic int active_jobs();
      if (jobs_reg == 0) return 1;
      if (jobs_reg > MAX_JOBS) return MAX_JOBS;
      return int'(jobs_reg);
   endfunction

   function automatic int active_machines();
      if (machines_reg == 0) return 1;
      if (machines_reg > MAX_MACHINES) return MAX_MACHINES;
      return int'(machines_reg);
   endfunction

   function automatic logic [SPAN_W-1:0] sequence_span(input int seq[MAX_JOBS], input int len,
                                                      input int mc);
      logic [SPAN_W-1:0] row[MAX_MACHINES];
      logic [SPAN_W-1:0] start;
      for (int m = 0; m < MAX_MACHINES; m++) row[m] = '0;
      for (int k = 0; k < len; k++) begin
         for (int m = 0; m < mc; m++) begin
            start = row[m];
            if (m > 0 && row[m-1] > start) start = row[m-1];
            row[m] = start + SPAN_W'(proc_times[seq[k]][m]);
         end
      end
      return row[mc-1];
   endfunction

   task automatic predict_schedule(input int jc, input int mc);
      int order[MAX_JOBS];
      int best[MAX_JOBS];
      int trial[MAX_JOBS];
      int chosen[MAX_JOBS];
      int j, v;
      logic [SPAN_W-1:0] span, best_span;
      sched_result_type r;
      for (int i = 0; i < jc; i++) begin
         v = i;
         j = i;
         while (j > 0 && job_sums[order[j-1]] < job_sums[v]) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = v;
      end
      best[0] = order[0];
      for (int i = 1; i < jc; i++) begin
         best_span = '1;
         for (int p = 0; p <= i; p++) begin
            for (int k = 0; k < p; k++) trial[k] = best[k];
            trial[p] = order[i];
            for (int k = p; k < i; k++) trial[k+1] = best[k];
            span = sequence_span(trial, i + 1, mc);
            if (p == 0 || span < best_span) begin
               best_span = span;
               chosen = trial;
            end
         end
         for (int k = 0; k <= i; k++) best[k] = chosen[k];
      end
      span = sequence_span(best, jc, mc);
      for (int k = 0; k < jc; k++) begin
         r.job_number = JC_W'(best[k] + 1);
         r.makespan   = span;
         r.last       = (k == jc - 1);
         sched_expect_q.push_back(r);
      end
   endtask

   task automatic report(input string what, input int got, input int want);
      $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   task automatic clear_load();
      loaded = 0;
      for (int j = 0; j < MAX_JOBS; j++) job_sums[j] = '0;
   endtask

   always @(posedge clock) begin
      int jc, mc, job, mach;
      sched_result_type want;
      if (reset) begin
         fail_count   = 0;
         result_count = 0;
         jobs_reg     = 1;
         machines_reg = 1;
         clear_load();
         sched_expect_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == nfs_pkg::CSR_JOB_COUNT) begin
               jobs_reg = csr_wdata;
               clear_load();
            end else if (csr_index == nfs_pkg::CSR_MACHINE_COUNT) begin
               machines_reg = csr_wdata[MC_W-1:0];
               clear_load();
            end
         end
         if (req_valid && !req_stall) begin
            jc = active_jobs();
            mc = active_machines();
            if (loaded >= jc * mc) loaded = 0;
            job  = loaded / mc;
            mach = loaded % mc;
            proc_times[job][mach] = req_proc_time;
            job_sums[job] += TOTAL_W'(req_proc_time);
            loaded++;
            if (loaded == jc * mc) begin
               predict_schedule(jc, mc);
               clear_load();
            end
         end
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (sched_expect_q.size() == 0) begin
               report("unexpected result, job_number", rsp_job_number, 0);
            end else begin
               want = sched_expect_q.pop_front();
               if (rsp_job_number !== want.job_number)
                  report("job_number", rsp_job_number, want.job_number);
               if (rsp_makespan !== want.makespan)
                  report("makespan", rsp_makespan, want.makespan);
               if (rsp_last !== want.last)
                  report("last", rsp_last, want.last);
            end
         end
      end
      pending = sched_expect_q.size();
   end
endmodule

/* sim/tb.sv */
// Testbench top: drives instances of the flow-shop scheduler and gives the verdict.
module tb;
   localparam int TIME_BITS = nfs_pkg::TIME_BITS;
   localparam int JC_W      = nfs_pkg::JC_W;
   localparam int SPAN_W    = nfs_pkg::SPAN_W;
   localparam int CSR_IDX_W = nfs_pkg::CSR_IDX_W;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE  = 2'd3;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [TIME_BITS-1:0] req_proc_time;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [JC_W-1:0]      rsp_job_number;
   logic [SPAN_W-1:0]    rsp_makespan;
   logic                 rsp_last;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [JC_W-1:0]      csr_wdata;
   int                   fail_count;
   int                   pending;
   int                   result_count;
   int                   burst_left;
   int                   random_items;
   int                   instances;

   neh_flow_shop_scheduler_unit uut (.*);

   nfs_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #200000000;
      $display("Timeout");
      $display("Mismatches found");
      $finish;
   end

   initial begin
      rsp_stall = 0;
      @(negedge clock);
      forever begin
         int mode, span_len;
         mode     = $urandom_range(0, 3);
         span_len = $urandom_range(5, 60);
         repeat (span_len) begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 1) == 1);
               2: rsp_stall <= ($urandom_range(0, 4) != 0);
               default: rsp_stall <= ($urandom_range(0, 5) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   task automatic send_time(input logic [TIME_BITS-1:0] t);
      if (burst_left == 0) begin
         int gap;
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 14);
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_proc_time <= t;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [JC_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [TIME_BITS-1:0] pick_time(input int style);
      case (style)
         0: return TIME_BITS'($urandom_range(0, 3));
         1: return TIME_BITS'($urandom_range(0, 40));
         default: return TIME_BITS'($urandom);
      endcase
   endfunction

   task automatic load_instance(input int jc, input int mc, input int style);
      for (int n = 0; n < jc * mc; n++) send_time(pick_time(style));
      instances++;
   endtask

   initial begin
      int jc, mc, style;
      reset         = 1;
      req_valid     = 0;
      req_proc_time = '0;
      csr_we        = 0;
      csr_index     = nfs_pkg::CSR_JOB_COUNT;
      csr_wdata     = '0;
      burst_left    = 0;
      random_items  = 0;
      instances     = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_time('0);
      send_time('1);
      go_idle();
      write_csr(nfs_pkg::CSR_JOB_COUNT, 6'd3);
      write_csr(nfs_pkg::CSR_MACHINE_COUNT, 6'd2);
      repeat (6) send_time('0);
      go_idle();
      write_csr(nfs_pkg::CSR_JOB_COUNT, 6'd2);
      repeat (4) send_time('1);
      go_idle();
      write_csr(CSR_UNUSED, 6'd5);
      write_csr(CSR_SPARE, 6'd63);
      repeat (3) send_time(pick_time(2));
      go_idle();
      write_csr(nfs_pkg::CSR_JOB_COUNT, 6'd4);
      write_csr(nfs_pkg::CSR_MACHINE_COUNT, 6'd3);
      load_instance(4, 3, 2);
      go_idle();
      write_csr(nfs_pkg::CSR_JOB_COUNT, 6'd0);
      write_csr(nfs_pkg::CSR_MACHINE_COUNT, 6'd0);
      send_time(pick_time(2));
      go_idle();
      write_csr(nfs_pkg::CSR_JOB_COUNT, 6'd63);
      write_csr(nfs_pkg::CSR_MACHINE_COUNT, 6'd32);
      load_instance(32, 1, 0);
      go_idle();
      write_csr(nfs_pkg::CSR_JOB_COUNT, 6'd2);
      write_csr(nfs_pkg::CSR_MACHINE_COUNT, 6'd31);
      load_instance(2, 16, 2);
      go_idle();

      while (random_items < 100) begin
         jc = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
         mc = $urandom_range(1, 5);
         if ($urandom_range(0, 1) == 1) begin
            write_csr(nfs_pkg::CSR_MACHINE_COUNT, JC_W'(mc));
            write_csr(nfs_pkg::CSR_JOB_COUNT, JC_W'(jc));
         end else begin
            write_csr(nfs_pkg::CSR_JOB_COUNT, JC_W'(jc));
            write_csr(nfs_pkg::CSR_MACHINE_COUNT, JC_W'(mc));
         end
         repeat ($urandom_range(1, 3)) begin
            style = $urandom_range(0, 2);
            load_instance(jc, mc, style);
            random_items += jc * mc;
            if ($urandom_range(0, 4) == 0) go_idle();
         end
         go_idle();
      end

      write_csr(nfs_pkg::CSR_JOB_COUNT, 6'd32);
      write_csr(nfs_pkg::CSR_MACHINE_COUNT, 6'd4);
      load_instance(32, 4, 2);
      go_idle();

      $display("Ran %0d instances (%0d random items), from 1x1 up to 32 jobs or 16 machines;",
               instances, random_items);
      $display("checked %0d scheduled jobs under random input gaps and output stalls.",
               result_count);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
